@@ sv/bpfl_pkg.sv @@
// Package for the buffer pool free list manager: field widths, defaults,
// function and status codes. No dependencies.
`timescale 1ns / 1ps

package bpfl_pkg;

    localparam int SLOT_COUNT_DEF = 256;

    localparam int FUNC_W   = 3;
    localparam int SIZE_W   = 32;
    localparam int HANDLE_W = 9;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 8;
    localparam int BYTES_W  = 17;
    localparam int COUNT_W  = 9;
    localparam int TOTAL_W  = 32;

    localparam logic [BYTES_W-1:0] DEFAULT_BYTES = 17'd4096;
    localparam logic [BYTES_W-1:0] MAX_BYTES     = 17'd65536;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC       = 3'd0,
        FUNC_FREE        = 3'd1,
        FUNC_RESIZE      = 3'd2,
        FUNC_QUERY       = 3'd3,
        FUNC_RESET_STATS = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_EXT_FREE  = 3'd3,
        ST_NO_ROOM   = 3'd4,
        ST_INVALID   = 3'd5
    } t_status;

endpackage

@@ sv/bpfl_if.sv @@
// Valid/ready channel interfaces for requests, results and the capacity write.
// Depends on bpfl_pkg.
`timescale 1ns / 1ps

interface bpfl_req_if;
    logic                          valid;
    logic                          ready;
    logic [bpfl_pkg::FUNC_W-1:0]   func;
    logic [bpfl_pkg::SIZE_W-1:0]   req_size;
    logic [bpfl_pkg::HANDLE_W-1:0] handle;

    modport source (output valid, func, req_size, handle, input ready);
    modport sink   (input valid, func, req_size, handle, output ready);
endinterface

interface bpfl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bpfl_pkg::STATUS_W-1:0] status;
    logic [bpfl_pkg::SLOT_W-1:0]   granted_slot;
    logic                          in_pool;
    logic [bpfl_pkg::BYTES_W-1:0]  slot_capacity;
    logic [bpfl_pkg::COUNT_W-1:0]  used_count;
    logic [bpfl_pkg::COUNT_W-1:0]  idle_count;
    logic [bpfl_pkg::TOTAL_W-1:0]  request_total;
    logic [bpfl_pkg::TOTAL_W-1:0]  hit_total;
    logic [bpfl_pkg::TOTAL_W-1:0]  miss_total;

    modport source (output valid, status, granted_slot, in_pool, slot_capacity,
                    used_count, idle_count, request_total, hit_total, miss_total,
                    input ready);
    modport sink   (input valid, status, granted_slot, in_pool, slot_capacity,
                    used_count, idle_count, request_total, hit_total, miss_total,
                    output ready);
endinterface

interface bpfl_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [bpfl_pkg::BYTES_W-1:0] buffer_bytes;

    modport source (output valid, buffer_bytes, input ready);
    modport sink   (input valid, buffer_bytes, output ready);
endinterface

@@ sv/bpfl_stack.sv @@
// LIFO free-slot stack: top entry cached in a register, the rest in a RAM
// with per-entry written bits (unwritten entry k reads as k). Uses bpfl_pkg.
`timescale 1ns / 1ps

module bpfl_stack #(
    parameter int SLOT_COUNT = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_pop,
    input  logic                                 i_push,
    input  logic [$clog2(SLOT_COUNT)-1:0]        i_push_slot,
    output logic [$clog2(SLOT_COUNT)-1:0]        o_top,
    output logic [$clog2(SLOT_COUNT+1)-1:0]      o_depth,
    output logic [$clog2(SLOT_COUNT+1)-1:0]      o_next_depth
);
    import bpfl_pkg::*;

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int DW = $clog2(SLOT_COUNT + 1);

    logic [SW-1:0]         r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_wr_vld;
    logic [DW-1:0]         r_depth;
    logic [SW-1:0]         r_top;
    logic [SW-1:0]         r_rd_addr;
    logic                  r_rd_vld;
    logic [SW-1:0]         r_rd_q;

    logic [DW-1:0] n_depth;
    logic [SW-1:0] n_top;
    logic [SW-1:0] below;
    logic [SW-1:0] rd_idx;
    logic [SW-1:0] wr_idx;

    // entry just under the top, prefetched from the RAM
    assign below  = r_rd_vld ? r_rd_q : r_rd_addr;
    assign wr_idx = r_depth[SW-1:0];

    always_comb begin
        n_depth = r_depth;
        n_top   = r_top;
        if (i_push) begin
            n_depth = r_depth + DW'(1);
            n_top   = i_push_slot;
        end else if (i_pop) begin
            n_depth = r_depth - DW'(1);
            n_top   = below;
        end
        if (n_depth >= DW'(2)) begin
            rd_idx = SW'(n_depth - DW'(2));
        end else begin
            rd_idx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= DW'(SLOT_COUNT);
            r_top     <= SW'(SLOT_COUNT - 1);
            r_wr_vld  <= '0;
            r_rd_addr <= SW'(SLOT_COUNT - 2);
            r_rd_vld  <= 1'b0;
        end else begin
            r_depth   <= n_depth;
            r_top     <= n_top;
            r_rd_addr <= rd_idx;
            r_rd_vld  <= r_wr_vld[rd_idx];
            if (i_push) begin
                r_wr_vld[wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[wr_idx] <= i_push_slot;
        end
        r_rd_q <= r_mem[rd_idx];
    end

    assign o_top        = r_top;
    assign o_depth      = r_depth;
    assign o_next_depth = n_depth;

`ifndef SYNTH
    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(SLOT_COUNT))
        else $error("stack depth above pool size");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_depth != '0)
        else $error("pop from empty stack");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_depth < DW'(SLOT_COUNT) && !i_pop))
        else $error("push into full stack or together with pop");
`endif

endmodule

@@ sv/buffer_pool_free_list_manager.sv @@
// Fixed-size buffer pool allocator: request register, combinational decode and
// state update, result register. Depends on bpfl_pkg, bpfl_if, bpfl_stack.
// A request goes from the request register to the result register; throughput
// 1 beat per cycle while the result register is not held by o_rsp.ready.
// Reset (synchronous, active low) restores a full stack and clears all in-use
// bits and counters at once; no clearing sweep, requests are taken at once.
`timescale 1ns / 1ps

module buffer_pool_free_list_manager #(
    parameter int SLOT_COUNT = bpfl_pkg::SLOT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bpfl_cfg_if.sink    i_cfg,
    bpfl_req_if.sink    i_req,
    bpfl_rsp_if.source  o_rsp
);
    import bpfl_pkg::*;

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int DW = $clog2(SLOT_COUNT + 1);

    // configuration
    logic [BYTES_W-1:0] r_bytes;

    // request register
    logic                r_in_vld;
    logic [FUNC_W-1:0]   r_func;
    logic [SIZE_W-1:0]   r_size;
    logic [HANDLE_W-1:0] r_handle;

    // state
    logic [SLOT_COUNT-1:0] r_busy;
    logic [DW-1:0]         r_busy_total;
    logic [TOTAL_W-1:0]    r_req_cnt;
    logic [TOTAL_W-1:0]    r_hit_cnt;
    logic [TOTAL_W-1:0]    r_miss_cnt;

    // result register
    logic                r_out_vld;
    logic [STATUS_W-1:0] r_status;
    logic [SLOT_W-1:0]   r_granted;
    logic                r_pooled;
    logic [BYTES_W-1:0]  r_cap;
    logic [COUNT_W-1:0]  r_used;
    logic [COUNT_W-1:0]  r_idle;
    logic [TOTAL_W-1:0]  r_req_out;
    logic [TOTAL_W-1:0]  r_hit_out;
    logic [TOTAL_W-1:0]  r_miss_out;

    logic                fire;
    logic                in_ready;
    logic                pooled;
    logic                in_use;
    logic                too_big;
    logic [SW-1:0]       h_idx;
    logic                pop;
    logic                push;
    logic [SW-1:0]       top;
    logic [DW-1:0]       depth;
    logic [DW-1:0]       next_depth;
    logic [STATUS_W-1:0] n_status;
    logic [SLOT_W-1:0]   n_granted;
    logic                n_pooled;
    logic [BYTES_W-1:0]  n_cap;
    logic [DW-1:0]       n_busy_total;
    logic [TOTAL_W-1:0]  n_req_cnt;
    logic [TOTAL_W-1:0]  n_hit_cnt;
    logic [TOTAL_W-1:0]  n_miss_cnt;
    logic [BYTES_W-1:0]  cfg_bytes;

    assign fire     = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign in_ready = !r_in_vld || fire;
    assign i_req.ready = in_ready;
    assign i_cfg.ready = 1'b1;

    assign h_idx   = r_handle[SW-1:0];
    assign pooled  = r_handle < HANDLE_W'(SLOT_COUNT);
    assign in_use  = pooled && r_busy[h_idx];
    assign too_big = r_size > SIZE_W'(r_bytes);

    always_comb begin
        if (i_cfg.buffer_bytes == '0) begin
            cfg_bytes = DEFAULT_BYTES;
        end else if (i_cfg.buffer_bytes > MAX_BYTES) begin
            cfg_bytes = MAX_BYTES;
        end else begin
            cfg_bytes = i_cfg.buffer_bytes;
        end
    end

    always_comb begin
        pop          = 1'b0;
        push         = 1'b0;
        n_status     = ST_OK;
        n_granted    = '0;
        n_pooled     = 1'b0;
        n_cap        = '0;
        n_busy_total = r_busy_total;
        n_req_cnt    = r_req_cnt;
        n_hit_cnt    = r_hit_cnt;
        n_miss_cnt   = r_miss_cnt;
        unique case (r_func)
            FUNC_ALLOC: begin
                n_req_cnt = r_req_cnt + TOTAL_W'(1);
                if (too_big) begin
                    n_miss_cnt = r_miss_cnt + TOTAL_W'(1);
                    n_status   = ST_TOO_LARGE;
                end else if (depth != '0) begin
                    pop          = fire;
                    n_granted    = SLOT_W'(top);
                    n_busy_total = r_busy_total + DW'(1);
                    n_hit_cnt    = r_hit_cnt + TOTAL_W'(1);
                end else begin
                    n_miss_cnt = r_miss_cnt + TOTAL_W'(1);
                    n_status   = ST_EXHAUSTED;
                end
            end
            FUNC_FREE: begin
                if (in_use && depth < DW'(SLOT_COUNT)) begin
                    push         = fire;
                    n_busy_total = r_busy_total - DW'(1);
                end else begin
                    n_status = ST_EXT_FREE;
                end
            end
            FUNC_RESIZE: begin
                if (!in_use) begin
                    n_status = ST_INVALID;
                end else if (too_big) begin
                    n_status = ST_NO_ROOM;
                end
            end
            FUNC_QUERY: begin
                n_pooled = pooled;
                n_cap    = in_use ? r_bytes : '0;
            end
            FUNC_RESET_STATS: begin
                n_req_cnt  = '0;
                n_hit_cnt  = '0;
                n_miss_cnt = '0;
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    bpfl_stack #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_stack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop        (pop),
        .i_push       (push),
        .i_push_slot  (h_idx),
        .o_top        (top),
        .o_depth      (depth),
        .o_next_depth (next_depth)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes      <= DEFAULT_BYTES;
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_busy       <= '0;
            r_busy_total <= '0;
            r_req_cnt    <= '0;
            r_hit_cnt    <= '0;
            r_miss_cnt   <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_bytes <= cfg_bytes;
            end
            if (in_ready) begin
                r_in_vld <= i_req.valid;
            end
            if (fire) begin
                r_out_vld    <= 1'b1;
                r_busy_total <= n_busy_total;
                r_req_cnt    <= n_req_cnt;
                r_hit_cnt    <= n_hit_cnt;
                r_miss_cnt   <= n_miss_cnt;
                if (pop) begin
                    r_busy[top] <= 1'b1;
                end
                if (push) begin
                    r_busy[h_idx] <= 1'b0;
                end
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_req.valid) begin
            r_func   <= i_req.func;
            r_size   <= i_req.req_size;
            r_handle <= i_req.handle;
        end
        if (fire) begin
            r_status   <= n_status;
            r_granted  <= n_granted;
            r_pooled   <= n_pooled;
            r_cap      <= n_cap;
            r_used     <= COUNT_W'(n_busy_total);
            r_idle     <= COUNT_W'(next_depth);
            r_req_out  <= n_req_cnt;
            r_hit_out  <= n_hit_cnt;
            r_miss_out <= n_miss_cnt;
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.status        = r_status;
    assign o_rsp.granted_slot  = r_granted;
    assign o_rsp.in_pool       = r_pooled;
    assign o_rsp.slot_capacity = r_cap;
    assign o_rsp.used_count    = r_used;
    assign o_rsp.idle_count    = r_idle;
    assign o_rsp.request_total = r_req_out;
    assign o_rsp.hit_total     = r_hit_out;
    assign o_rsp.miss_total    = r_miss_out;

`ifndef SYNTH
    a_slots_conserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_used + r_idle) == COUNT_W'(SLOT_COUNT))
        else $error("used plus idle slots differ from pool size");
    a_hits_plus_misses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> TOTAL_W'(r_hit_out + r_miss_out) == r_req_out)
        else $error("hit and miss totals do not add up to requests");
    a_grant_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_status != ST_OK) |-> r_granted == '0)
        else $error("slot granted on a failed request");
    a_busy_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy_total == DW'($countones(r_busy)))
        else $error("in-use count out of step with in-use bits");
`endif

endmodule
